>>> sv/rcdp_pkg.sv
// shared constants for the complex-sample real-coefficient dot product
`timescale 1ns / 1ps
package rcdp_pkg;

   // fixed field widths
   localparam int TAP_W   = 11;
   localparam int INDEX_W = 10;
   localparam int ACC_W   = 42;

   // defaults for the top level parameters
   localparam int DEF_MAX_TAPS     = 1024;
   localparam int DEF_COEF_WIDTH   = 16;
   localparam int DEF_SAMPLE_WIDTH = 16;

   // request word kinds
   localparam logic REQ_LOAD   = 1'b0;
   localparam logic REQ_SAMPLE = 1'b1;

endpackage

>>> sv/rcdp_if.sv
// request and response channel interfaces
`timescale 1ns / 1ps
interface rcdp_req_if #(
   parameter int COEF_WIDTH   = rcdp_pkg::DEF_COEF_WIDTH,
   parameter int SAMPLE_WIDTH = rcdp_pkg::DEF_SAMPLE_WIDTH
);
   import rcdp_pkg::*;

   logic                           valid;
   logic                           ready;
   logic                           req_type;
   logic        [INDEX_W-1:0]      coef_index;
   logic signed [COEF_WIDTH-1:0]   coef_value;
   logic signed [SAMPLE_WIDTH-1:0] sample_re;
   logic signed [SAMPLE_WIDTH-1:0] sample_im;

   modport source (
      output valid, req_type, coef_index, coef_value, sample_re, sample_im,
      input  ready
   );
   modport sink (
      input  valid, req_type, coef_index, coef_value, sample_re, sample_im,
      output ready
   );
endinterface

interface rcdp_rsp_if;
   import rcdp_pkg::*;

   logic                    valid;
   logic                    ready;
   logic signed [ACC_W-1:0] dot_re;
   logic signed [ACC_W-1:0] dot_im;

   modport source (
      output valid, dot_re, dot_im,
      input  ready
   );
   modport sink (
      input  valid, dot_re, dot_im,
      output ready
   );
endinterface

>>> sv/real_coef_complex_dot_product.sv
// complex-sample dot product with a real coefficient table in ram
//
//  channel | dir | handshake            | payload
//  req     | in  | req.valid/req.ready  | req_type, coef_index, coef_value, sample_re/im
//  rsp     | out | rsp.valid/rsp.ready  | dot_re, dot_im
//  csr     | in  | csr_we               | csr_wdata = tap_count
//
// one word per cycle while req.ready is high, loads and samples alike; the
// coefficient ram read, the multiply and the accumulate are one stage each,
// and a completing sample's sum reaches rsp through their registers. reset
// is synchronous and clears the position, the sums, tap_count (to 1) and all
// stage valids; the table is not cleared. a waiting result holds a completing
// sample in the product stage; loads still go in until a sample waits behind
// it, then req.ready drops until rsp is taken.
`timescale 1ns / 1ps
module real_coef_complex_dot_product #(
   parameter int MAX_TAPS     = rcdp_pkg::DEF_MAX_TAPS,
   parameter int COEF_WIDTH   = rcdp_pkg::DEF_COEF_WIDTH,
   parameter int SAMPLE_WIDTH = rcdp_pkg::DEF_SAMPLE_WIDTH
) (
   input  logic                       clock,
   input  logic                       reset,
   rcdp_req_if.sink                   req,
   rcdp_rsp_if.source                 rsp,
   input  logic                       csr_we,
   input  logic [rcdp_pkg::TAP_W-1:0] csr_wdata
);
   import rcdp_pkg::*;

   localparam int ADDR_W    = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
   localparam int CMP_W     = (TAP_W > ADDR_W + 1) ? TAP_W : ADDR_W + 1;
   localparam int IDX_CMP_W = (INDEX_W > ADDR_W) ? INDEX_W + 1 : ADDR_W + 1;
   localparam int PROD_W    = COEF_WIDTH + SAMPLE_WIDTH;

   // configuration
   logic [TAP_W-1:0] tap_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_ff <= TAP_W'(1);
      end else if (csr_we) begin
         tap_ff <= csr_wdata;
      end
   end

   // pipeline flow control
   logic out_free, s2_go, s2_free, s1_go, s1_free;
   logic s1_valid_ff, s1_last_ff;
   logic s2_valid_ff, s2_last_ff;
   logic rsp_valid_ff;

   assign out_free = !rsp_valid_ff || rsp.ready;
   assign s2_go    = s2_valid_ff && (!s2_last_ff || out_free);
   assign s2_free  = !s2_valid_ff || s2_go;
   assign s1_go    = s1_valid_ff && s2_free;
   assign s1_free  = !s1_valid_ff || s1_go;
   assign req.ready = s1_free;

   logic accept, smp_acc, ld_acc;
   assign accept  = req.valid && s1_free;
   assign smp_acc = accept && (req.req_type == REQ_SAMPLE);
   assign ld_acc  = accept && (req.req_type == REQ_LOAD) &&
                    (IDX_CMP_W'(req.coef_index) < IDX_CMP_W'(MAX_TAPS));

   // sample position and end-of-sum detect
   logic [ADDR_W-1:0] pos_ff, pos_in;
   logic [CMP_W-1:0]  pos_next;
   logic              last_hit;

   assign pos_next = CMP_W'(pos_ff) + CMP_W'(1);
   assign last_hit = (pos_next >= CMP_W'(tap_ff)) || (pos_next >= CMP_W'(MAX_TAPS));
   assign pos_in   = last_hit ? '0 : ADDR_W'(pos_next);

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else if (smp_acc) begin
         pos_ff <= pos_in;
      end
   end

   // coefficient table
   logic [COEF_WIDTH-1:0] coef_rd;

   rcdp_ram #(
      .WIDTH  (COEF_WIDTH),
      .DEPTH  (MAX_TAPS),
      .ADDR_W (ADDR_W)
   ) u_coef_ram (
      .clock   (clock),
      .wr_en   (ld_acc),
      .wr_addr (ADDR_W'(req.coef_index)),
      .wr_data (req.coef_value),
      .rd_en   (smp_acc),
      .rd_addr (pos_ff),
      .rd_data (coef_rd)
   );

   // stage 1: coefficient comes back from ram
   logic signed [SAMPLE_WIDTH-1:0] s1_re_ff, s1_im_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_free) begin
         s1_valid_ff <= smp_acc;
      end
   end

   always_ff @(posedge clock) begin
      if (smp_acc) begin
         s1_last_ff <= last_hit;
         s1_re_ff   <= req.sample_re;
         s1_im_ff   <= req.sample_im;
      end
   end

   // stage 2: registered products
   logic signed [COEF_WIDTH-1:0] coef_s;
   logic signed [PROD_W-1:0]     prod_re_in, prod_im_in;
   logic signed [PROD_W-1:0]     s2_prod_re_ff, s2_prod_im_ff;

   assign coef_s     = coef_rd;
   assign prod_re_in = coef_s * s1_re_ff;
   assign prod_im_in = coef_s * s1_im_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_free) begin
         s2_valid_ff <= s1_go;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go) begin
         s2_last_ff    <= s1_last_ff;
         s2_prod_re_ff <= prod_re_in;
         s2_prod_im_ff <= prod_im_in;
      end
   end

   // accumulate, hand the finished sum to the output register
   logic signed [ACC_W-1:0] acc_re_ff, acc_im_ff;
   logic signed [ACC_W-1:0] sum_re_in, sum_im_in;
   logic signed [ACC_W-1:0] dot_re_ff, dot_im_ff;

   assign sum_re_in = acc_re_ff + ACC_W'(s2_prod_re_ff);
   assign sum_im_in = acc_im_ff + ACC_W'(s2_prod_im_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_re_ff <= '0;
         acc_im_ff <= '0;
      end else if (s2_go) begin
         acc_re_ff <= s2_last_ff ? '0 : sum_re_in;
         acc_im_ff <= s2_last_ff ? '0 : sum_im_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s2_go && s2_last_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_go && s2_last_ff) begin
         dot_re_ff <= sum_re_in;
         dot_im_ff <= sum_im_in;
      end
   end

   assign rsp.valid  = rsp_valid_ff;
   assign rsp.dot_re = dot_re_ff;
   assign rsp.dot_im = dot_im_ff;

`ifndef SYNTHESIS
   // position stays inside the table
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      CMP_W'(pos_ff) < CMP_W'(MAX_TAPS))
      else $error("sample position beyond table");

   // a completing sample restarts the position
   a_pos_wrap: assert property (@(posedge clock) disable iff (reset)
      smp_acc && last_hit |=> pos_ff == '0)
      else $error("position not cleared after completing sample");

   // a new result only comes from a completing sample leaving stage 2
   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s2_go && s2_last_ff))
      else $error("result without completing sample");

   // a held product stage keeps its products
   a_s2_hold: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff && !s2_go |=> s2_valid_ff && $stable(s2_prod_re_ff) &&
                                $stable(s2_prod_im_ff))
      else $error("stalled products changed");
`endif
endmodule

>>> sv/rcdp_ram.sv
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps
module rcdp_ram #(
   parameter int WIDTH  = 16,
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, data holds when not reading
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule
